// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle whenever ante holds.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that cons holds in the cycle after ante holds.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// File: sv/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// Types and codes shared by the sorted byte list and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sbl_pkg;

	localparam int unsigned DATA_W   = 8;
	localparam int unsigned STATUS_W = 3;
	localparam int unsigned COUNT_W  = 5;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} sbl_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_FULL      = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_EMPTY     = 3'd4
	} sbl_status_t;

	// Broadcast command, already qualified by acceptance and list state
	typedef struct packed {
		logic              ins;
		logic              del;
		logic [DATA_W-1:0] value;
	} sbl_cmd_t;

	// What a cell shows its neighbors and the control
	typedef struct packed {
		logic [DATA_W-1:0] data;
		logic              valid;
		logic              lt;
		logic              hit;
	} sbl_link_t;

endpackage

`default_nettype wire

// File: sv/sbl_cell.sv
// ----------------------------------------------------------------------------
// sbl_cell
// One slot of the sorted list: holds a byte and an occupied bit, compares
// against the broadcast value and shifts toward either neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sbl_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire sbl_pkg::sbl_cmd_t  cmd,
	input  wire sbl_pkg::sbl_link_t left,
	input  wire sbl_pkg::sbl_link_t right,
	output sbl_pkg::sbl_link_t      link
);

	logic [sbl_pkg::DATA_W-1:0] entry_q;
	logic                       valid_q;
	logic                       lt;
	logic                       take_new;
	logic                       take_left;
	logic                       take_right;

	// Compare stored entry against the request value
	assign lt = valid_q && (entry_q < cmd.value);

	assign link = '{data: entry_q, valid: valid_q, lt: lt,
		hit: valid_q && (entry_q == cmd.value)};

	// Insert point is the first cell not below the value; cells past it shift up
	assign take_new   = cmd.ins && !lt && left.lt;
	assign take_left  = cmd.ins && !lt && !left.lt;
	// Delete point is the first cell not below the value; it and all after shift down
	assign take_right = cmd.del && !lt;

	// Advance the occupied bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_left) begin
			valid_q <= left.valid;
		end else if (take_right) begin
			valid_q <= right.valid;
		end
	end

	// Advance the stored byte
	always_ff @(posedge clk) begin
		if (take_new) begin
			entry_q <= cmd.value;
		end else if (take_left) begin
			entry_q <= left.data;
		end else if (take_right) begin
			entry_q <= right.data;
		end
	end

endmodule

`default_nettype wire

// File: sv/sorted_byte_list.sv
// Result: registered, valid in the cycle after its request is accepted.
// Throughput: one request per cycle unless stalled; each cell compares and
// shifts at once, so a row of CAPACITY cells finishes any insert or delete.
// Reset: arst_n clears the entry count, all occupied bits and the output valid;
// stored bytes are not cleared and are never read while unoccupied.
// ----------------------------------------------------------------------------
// sorted_byte_list
// Bounded ascending list of bytes with insert and delete requests, built as a
// row of compare-and-shift cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sorted_byte_list #(
	parameter int unsigned CAPACITY = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           opcode,
	input  wire logic [sbl_pkg::DATA_W-1:0]     value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [sbl_pkg::STATUS_W-1:0]        status,
	output logic [sbl_pkg::COUNT_W-1:0]         entry_count,
	output logic                                is_empty
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	sbl_pkg::sbl_link_t    link [CAPACITY];
	logic [CAPACITY-1:0]   valid_vec;
	logic [CAPACITY-1:0]   hit_vec;
	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic                  in_acc;
	logic                  full;
	logic                  empty;
	logic                  found;
	logic                  is_ins;
	sbl_pkg::sbl_cmd_t     cmd;
	sbl_pkg::sbl_status_t  status_d;
	logic                  out_valid_q;
	logic [sbl_pkg::STATUS_W-1:0] status_q;
	logic [sbl_pkg::COUNT_W-1:0]  entry_count_q;
	logic                  is_empty_q;

	// Accept while the result register is free or draining this cycle
	assign in_stall = out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;
	assign is_ins   = (opcode == sbl_pkg::OP_INSERT);

	// Gather cell flags
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			valid_vec[i] = link[i].valid;
			hit_vec[i]   = link[i].hit;
		end
	end

	assign full  = valid_vec[CAPACITY-1];
	assign empty = !valid_vec[0];
	assign found = |hit_vec;

	// Qualify the broadcast command
	assign cmd = '{ins: in_acc && is_ins && !full,
		del: in_acc && !is_ins && found,
		value: value};

	// Build the row of cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		sbl_pkg::sbl_link_t left_l;
		sbl_pkg::sbl_link_t right_l;
		if (g == 0) begin : g_head
			assign left_l = '{data: '0, valid: 1'b1, lt: 1'b1, hit: 1'b0};
		end else begin : g_mid_l
			assign left_l = link[g-1];
		end
		if (g == CAPACITY - 1) begin : g_tail
			assign right_l = '{data: '0, valid: 1'b0, lt: 1'b0, hit: 1'b0};
		end else begin : g_mid_r
			assign right_l = link[g+1];
		end
		sbl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd),
			.left   (left_l),
			.right  (right_l),
			.link   (link[g])
		);
	end

	// Next count and status
	always_comb begin
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + CW'(1);
		end else if (cmd.del) begin
			count_d = count_q - CW'(1);
		end
		priority if (is_ins && full) begin
			status_d = sbl_pkg::ST_FULL;
		end else if (is_ins) begin
			status_d = sbl_pkg::ST_INSERTED;
		end else if (empty) begin
			status_d = sbl_pkg::ST_EMPTY;
		end else if (found) begin
			status_d = sbl_pkg::ST_DELETED;
		end else begin
			status_d = sbl_pkg::ST_NOT_FOUND;
		end
	end

	// Hold the entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_acc) begin
			count_q <= count_d;
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			status_q      <= status_d;
			entry_count_q <= sbl_pkg::COUNT_W'(count_d);
			is_empty_q    <= (count_d == '0);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign entry_count = entry_count_q;
	assign is_empty    = is_empty_q;

	// Occupied cells always match the count
	`ASSERT_IMP(a_count_cells, clk, arst_n, 1'b1, $countones(valid_vec) == count_q)
	// An accepted insert with room grows the list by one
	`ASSERT_NEXT(a_ins_grow, clk, arst_n, cmd.ins, count_q == $past(count_q) + CW'(1))
	// A successful insert never leaves the list empty
	`ASSERT_IMP(a_ins_nonempty, clk, arst_n,
		out_valid_q && (status_q == sbl_pkg::ST_INSERTED), !is_empty_q)

endmodule

`default_nettype wire
